// ===== sv/dtts_pkg.sv =====
// Shared types, constants and unit-word lookup for the duration text parser.
// No dependencies; the scanner, the adder and the top level use this package.
`default_nettype none

package dtts_pkg;

    // Longest unit word kept; longer words are unknown
    localparam int MAX_UNIT_LETTERS = 7;
    // Longest word in the unit table
    localparam int TABLE_LETTERS    = 7;

    localparam int NUM_W  = 63;
    localparam int MULT_W = 25;
    localparam int LO_W   = 32;
    localparam int HI_W   = NUM_W - LO_W;
    localparam int PROD_W = NUM_W + MULT_W;

    localparam logic [MULT_W-1:0] SECS_SEC   = MULT_W'(1);
    localparam logic [MULT_W-1:0] SECS_MIN   = MULT_W'(60);
    localparam logic [MULT_W-1:0] SECS_HOUR  = MULT_W'(60 * 60);
    localparam logic [MULT_W-1:0] SECS_DAY   = MULT_W'(24 * 60 * 60);
    localparam logic [MULT_W-1:0] SECS_WEEK  = MULT_W'(7 * 24 * 60 * 60);
    localparam logic [MULT_W-1:0] SECS_MONTH = MULT_W'(30 * 24 * 60 * 60);
    localparam logic [MULT_W-1:0] SECS_YEAR  = MULT_W'(365 * 24 * 60 * 60);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_NODIGIT  = 3'd2,
        ST_NUMBIG   = 3'd3,
        ST_UNKNOWN  = 3'd4,
        ST_TOTALBIG = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        UNIT_NONE,
        UNIT_SEC,
        UNIT_MIN,
        UNIT_HOUR,
        UNIT_DAY,
        UNIT_WEEK,
        UNIT_MONTH,
        UNIT_YEAR
    } t_unit;

    // Control flags that travel with one parse event down the pipeline
    typedef struct packed {
        logic close;     // a part is closed by this event
        logic too_big;   // that part's number exceeded 2^63-1
        logic nodigit;   // a part start without a digit follows
        logic last;      // end of text: deliver a result
        logic any;       // at least one part closed in this text
    } t_tag;

    typedef struct packed {
        t_tag             tag;
        t_unit            unit;
        logic [NUM_W-1:0] num;
    } t_evt;

    // Match a unit word; letter 0 sits in the low byte of w
    function automatic t_unit unit_lookup(input logic [8*TABLE_LETTERS-1:0] w,
                                          input logic [4:0] len);
        logic [7:0]  c0, c1, c2, c3, c4, c5, c6;
        logic [15:0] w2;
        logic [23:0] w3;
        logic [31:0] w4;
        logic [39:0] w5;
        logic [47:0] w6;
        logic [55:0] w7;
        t_unit       u;
        c0 = w[7:0];
        c1 = w[15:8];
        c2 = w[23:16];
        c3 = w[31:24];
        c4 = w[39:32];
        c5 = w[47:40];
        c6 = w[55:48];
        w2 = {c0, c1};
        w3 = {c0, c1, c2};
        w4 = {c0, c1, c2, c3};
        w5 = {c0, c1, c2, c3, c4};
        w6 = {c0, c1, c2, c3, c4, c5};
        w7 = {c0, c1, c2, c3, c4, c5, c6};
        u  = UNIT_NONE;
        case (len)
            5'd0: u = UNIT_SEC;
            5'd1: begin
                case (c0)
                    "s":     u = UNIT_SEC;
                    "m":     u = UNIT_MIN;
                    "h":     u = UNIT_HOUR;
                    "d":     u = UNIT_DAY;
                    "w":     u = UNIT_WEEK;
                    "y":     u = UNIT_YEAR;
                    default: u = UNIT_NONE;
                endcase
            end
            5'd2: begin
                if (w2 == "mo") u = UNIT_MONTH;
            end
            5'd3: begin
                case (w3)
                    "sec":   u = UNIT_SEC;
                    "min":   u = UNIT_MIN;
                    "day":   u = UNIT_DAY;
                    default: u = UNIT_NONE;
                endcase
            end
            5'd4: begin
                case (w4)
                    "hour":  u = UNIT_HOUR;
                    "days":  u = UNIT_DAY;
                    "week":  u = UNIT_WEEK;
                    "year":  u = UNIT_YEAR;
                    default: u = UNIT_NONE;
                endcase
            end
            5'd5: begin
                case (w5)
                    "hours": u = UNIT_HOUR;
                    "weeks": u = UNIT_WEEK;
                    "month": u = UNIT_MONTH;
                    "years": u = UNIT_YEAR;
                    default: u = UNIT_NONE;
                endcase
            end
            5'd6: begin
                case (w6)
                    "second": u = UNIT_SEC;
                    "minute": u = UNIT_MIN;
                    "months": u = UNIT_MONTH;
                    default:  u = UNIT_NONE;
                endcase
            end
            5'd7: begin
                case (w7)
                    "seconds": u = UNIT_SEC;
                    "minutes": u = UNIT_MIN;
                    default:   u = UNIT_NONE;
                endcase
            end
            default: u = UNIT_NONE;
        endcase
        return u;
    endfunction

    // Seconds of one unit; zero for an unknown word
    function automatic logic [MULT_W-1:0] unit_secs(input t_unit u);
        logic [MULT_W-1:0] s;
        case (u)
            UNIT_SEC:   s = SECS_SEC;
            UNIT_MIN:   s = SECS_MIN;
            UNIT_HOUR:  s = SECS_HOUR;
            UNIT_DAY:   s = SECS_DAY;
            UNIT_WEEK:  s = SECS_WEEK;
            UNIT_MONTH: s = SECS_MONTH;
            UNIT_YEAR:  s = SECS_YEAR;
            default:    s = '0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== sv/dtts_if.sv =====
// Valid/ready channel interfaces for the duration text parser.
// Depends on nothing; used by the top level and its submodules.
`default_nettype none

interface dtts_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_code;

    modport source (output valid, kind, char_code, input ready);
    modport sink   (input valid, kind, char_code, output ready);
endinterface

interface dtts_out_if;
    logic        valid;
    logic        ready;
    logic [62:0] total_seconds;
    logic [2:0]  status;

    modport source (output valid, total_seconds, status, input ready);
    modport sink   (input valid, total_seconds, status, output ready);
endinterface

`default_nettype wire

// ===== sv/dtts_parse.sv =====
// Character front end: scans one byte per cycle while the adder is ready, and
// emits part-close, no-digit and end events. Depends on dtts_pkg and dtts_in_if.
`default_nettype none

module dtts_parse #(
    parameter int MAX_UNIT_LETTERS = dtts_pkg::MAX_UNIT_LETTERS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    dtts_in_if.sink            i_in,
    input  wire logic          i_evt_ready,
    output logic               o_evt_valid,
    output dtts_pkg::t_evt     o_evt
);

    localparam int LW = $clog2(MAX_UNIT_LETTERS + 2);
    localparam int NW = dtts_pkg::NUM_W;
    localparam int TL = dtts_pkg::TABLE_LETTERS;

    typedef enum logic [2:0] {
        PH_START,
        PH_NUMBER,
        PH_GAP,
        PH_UNIT,
        PH_FAILED
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [NW-1:0]   r_num, n_num;
    logic            r_big, n_big;
    logic [7:0]      r_letters [MAX_UNIT_LETTERS];
    logic [LW-1:0]   r_ulen, n_ulen;
    logic            r_any, n_any;

    logic            accept;
    logic [7:0]      c;
    logic            is_sp, is_dg, is_lt;
    logic [NW+3:0]   n10;
    logic            add, close, start, nodig, last;
    logic [8*TL-1:0] window;

    assign accept     = i_in.valid && i_evt_ready;
    assign i_in.ready = i_evt_ready;
    assign c          = i_in.char_code;

    // Classify the byte
    assign is_sp = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    assign is_dg = (c >= 8'd48) && (c <= 8'd57);
    assign is_lt = (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);

    // Next decimal value: 10 * n + digit, four guard bits for overflow
    assign n10 = ({4'b0, r_num} << 3) + ({4'b0, r_num} << 1) + (NW + 4)'(c[3:0]);

    // First table-length letters of the unit word
    always_comb begin
        for (int i = 0; i < TL; i++) begin
            window[8*i +: 8] = r_letters[i];
        end
    end

    // Advance the scan state on each transfer
    always_comb begin
        n_phase = r_phase;
        n_num   = r_num;
        n_big   = r_big;
        n_ulen  = r_ulen;
        n_any   = r_any;
        add     = 1'b0;
        close   = 1'b0;
        start   = 1'b0;
        nodig   = 1'b0;
        last    = 1'b0;
        if (accept) begin
            if (i_in.kind) begin
                last    = 1'b1;
                close   = (r_phase == PH_NUMBER) || (r_phase == PH_GAP) ||
                          (r_phase == PH_UNIT);
                n_phase = PH_START;
                n_ulen  = '0;
            end else begin
                unique case (r_phase)
                    PH_START: start = 1'b1;
                    PH_NUMBER: begin
                        if (is_dg) begin
                            if (r_big || (|n10[NW+3:NW])) begin
                                n_big = 1'b1;
                            end else begin
                                n_num = n10[NW-1:0];
                            end
                        end else if (is_sp) begin
                            n_phase = PH_GAP;
                        end else if (is_lt) begin
                            add = 1'b1;
                        end else begin
                            close = 1'b1;
                            start = 1'b1;
                        end
                    end
                    PH_GAP: begin
                        if (is_lt) begin
                            add = 1'b1;
                        end else if (!is_sp) begin
                            close = 1'b1;
                            start = 1'b1;
                        end
                    end
                    PH_UNIT: begin
                        if (is_lt) begin
                            add = 1'b1;
                        end else begin
                            close = 1'b1;
                            start = 1'b1;
                        end
                    end
                    PH_FAILED: ;
                    default: ;
                endcase
            end

            // Collect a unit letter; the count saturates one past the limit
            if (add) begin
                n_phase = PH_UNIT;
                if (r_ulen <= LW'(MAX_UNIT_LETTERS)) begin
                    n_ulen = r_ulen + LW'(1);
                end
            end

            // Open the next part, or flag a part with no leading digit
            if (start) begin
                if (is_sp) begin
                    n_phase = PH_START;
                end else if (is_dg) begin
                    n_num   = NW'(c[3:0]);
                    n_big   = 1'b0;
                    n_ulen  = '0;
                    n_phase = PH_NUMBER;
                end else begin
                    nodig   = 1'b1;
                    n_phase = PH_FAILED;
                end
            end

            n_any = last ? 1'b0 : (r_any || close);
        end
    end

    // Build the event for the arithmetic pipeline
    always_comb begin
        o_evt_valid         = accept && (close || nodig || last);
        o_evt.tag.close     = close;
        o_evt.tag.too_big   = r_big;
        o_evt.tag.nodigit   = nodig;
        o_evt.tag.last      = last;
        o_evt.tag.any       = r_any || close;
        o_evt.unit          = dtts_pkg::unit_lookup(window, 5'(r_ulen));
        o_evt.num           = r_num;
    end

    // Hold scan control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_ulen  <= '0;
            r_any   <= 1'b0;
            r_big   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_ulen  <= n_ulen;
            r_any   <= n_any;
            r_big   <= n_big;
        end
    end

    // Hold number and unit letters
    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        for (int i = 0; i < MAX_UNIT_LETTERS; i++) begin
            if (add && (r_ulen == LW'(i))) begin
                r_letters[i] <= c;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/dtts_accum.sv =====
// Arithmetic back end: unit multiply in two halves, overflow checks, running
// total, first-error latch and the result register. Depends on dtts_pkg.
`default_nettype none

module dtts_accum (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_evt_valid,
    input  dtts_pkg::t_evt     i_evt,
    output logic               o_evt_ready,
    dtts_out_if.source         o_out
);

    localparam int NW = dtts_pkg::NUM_W;
    localparam int MW = dtts_pkg::MULT_W;
    localparam int LO = dtts_pkg::LO_W;
    localparam int HI = dtts_pkg::HI_W;
    localparam int PW = dtts_pkg::PROD_W;

    // Stage 1: event as parsed
    logic               r_s1_v;
    dtts_pkg::t_evt     r_s1;
    // Stage 2: partial products
    logic               r_s2_v;
    dtts_pkg::t_tag     r_s2_tag;
    logic               r_s2_uok;
    logic [LO+MW-1:0]   r_s2_lo;
    logic [HI+MW-1:0]   r_s2_hi;
    // Stage 3: full product
    logic               r_s3_v;
    dtts_pkg::t_tag     r_s3_tag;
    logic               r_s3_uok;
    logic [NW-1:0]      r_s3_prod;
    logic               r_s3_povf;
    // Accumulator
    logic [NW-1:0]      r_tot, n_tot;
    dtts_pkg::t_status  r_err, n_err;
    // Result register
    logic               r_out_v;
    logic [NW-1:0]      r_out_tot;
    dtts_pkg::t_status  r_out_st;

    logic               out_free, s3_go, s3_rdy, s2_rdy, s1_rdy;
    logic [MW-1:0]      mult;
    logic [PW-1:0]      full;
    logic [NW:0]        sum;
    dtts_pkg::t_status  res_st;

    // Stage handshake: only an end event waits for the result register
    assign out_free    = !r_out_v || o_out.ready;
    assign s3_go       = r_s3_v && (!r_s3_tag.last || out_free);
    assign s3_rdy      = !r_s3_v || s3_go;
    assign s2_rdy      = !r_s2_v || s3_rdy;
    assign s1_rdy      = !r_s1_v || s2_rdy;
    assign o_evt_ready = s1_rdy;

    assign mult = dtts_pkg::unit_secs(r_s1.unit);
    assign full = {r_s2_hi, LO'(0)} + PW'(r_s2_lo);
    assign sum  = {1'b0, r_tot} + {1'b0, r_s3_prod};

    // Close a part: first error wins, then a stray byte, then the end
    always_comb begin
        n_tot  = r_tot;
        n_err  = r_err;
        if (r_err == dtts_pkg::ST_OK && r_s3_tag.close) begin
            if (r_s3_tag.too_big) begin
                n_err = dtts_pkg::ST_NUMBIG;
            end else if (!r_s3_uok) begin
                n_err = dtts_pkg::ST_UNKNOWN;
            end else if (r_s3_povf || sum[NW]) begin
                n_err = dtts_pkg::ST_TOTALBIG;
            end else begin
                n_tot = sum[NW-1:0];
            end
        end
        if (n_err == dtts_pkg::ST_OK && r_s3_tag.nodigit) begin
            n_err = dtts_pkg::ST_NODIGIT;
        end
        res_st = (n_err == dtts_pkg::ST_OK && !r_s3_tag.any) ? dtts_pkg::ST_EMPTY : n_err;
    end

    // Advance stage valids, accumulator and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_tot   <= '0;
            r_err   <= dtts_pkg::ST_OK;
            r_out_v <= 1'b0;
        end else begin
            if (s1_rdy) r_s1_v <= i_evt_valid;
            if (s2_rdy) r_s2_v <= r_s1_v;
            if (s3_rdy) r_s3_v <= r_s2_v;
            if (s3_go) begin
                if (r_s3_tag.last) begin
                    r_tot <= '0;
                    r_err <= dtts_pkg::ST_OK;
                end else begin
                    r_tot <= n_tot;
                    r_err <= n_err;
                end
            end
            if (s3_go && r_s3_tag.last) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Move stage payloads
    always_ff @(posedge i_clk) begin
        if (s1_rdy) r_s1 <= i_evt;
        if (s2_rdy) begin
            r_s2_tag <= r_s1.tag;
            r_s2_uok <= (r_s1.unit != dtts_pkg::UNIT_NONE);
            r_s2_lo  <= r_s1.num[LO-1:0] * mult;
            r_s2_hi  <= r_s1.num[NW-1:LO] * mult;
        end
        if (s3_rdy) begin
            r_s3_tag  <= r_s2_tag;
            r_s3_uok  <= r_s2_uok;
            r_s3_prod <= full[NW-1:0];
            r_s3_povf <= |full[PW-1:NW];
        end
        if (s3_go && r_s3_tag.last) begin
            r_out_tot <= n_tot;
            r_out_st  <= res_st;
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.total_seconds = r_out_tot;
    assign o_out.status        = r_out_st;

endmodule

`default_nettype wire

// ===== sv/duration_text_to_seconds_top.sv =====
// Duration text to seconds: top level joining the scanner and the adder.
// Depends on dtts_pkg, dtts_if, dtts_parse and dtts_accum.
//
// Usage:
//   i_in carries one transfer per text byte (kind = 0, char_code = byte)
//   and one end marker (kind = 1) after the last byte. Parts are a decimal
//   number, optional spaces and an optional unit word (s, m, h, d, w, mo,
//   y and their long forms). o_out carries one result per end marker:
//   total_seconds and status (ok, empty, no leading digit, number overflow,
//   unknown unit, total overflow); the first error of a text is reported.
//   Throughput: one byte or end marker per cycle while the receiver takes results.
//   Path: an end marker passes the event register, the 32x25 and 31x25
//   halves of the unit multiply, the product combine, then the
//   running-total add into the result register.
//   When the receiver stalls, the result register holds its value and
//   bytes keep flowing until an end marker reaches the adder; the pipeline
//   then fills and i_in.ready drops.
//   Reset (synchronous, active low) clears the scan state, running total,
//   error latch and all valids; the block takes bytes in the next cycle.
`default_nettype none

module duration_text_to_seconds_top #(
    parameter int MAX_UNIT_LETTERS = dtts_pkg::MAX_UNIT_LETTERS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dtts_in_if.sink    i_in,
    dtts_out_if.source o_out
);

    logic           evt_valid;
    logic           evt_ready;
    dtts_pkg::t_evt evt;

    // Scan bytes into part events
    dtts_parse #(
        .MAX_UNIT_LETTERS(MAX_UNIT_LETTERS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_evt_ready (evt_ready),
        .o_evt_valid (evt_valid),
        .o_evt       (evt)
    );

    // Multiply, sum and report
    dtts_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (evt_valid),
        .i_evt       (evt),
        .o_evt_ready (evt_ready),
        .o_out       (o_out)
    );

    // An empty text reports a zero total
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == 3'(dtts_pkg::ST_EMPTY))
        |-> (o_out.total_seconds == '0))
        else $error("empty result with nonzero total");

    // Status stays within the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.status <= 3'(dtts_pkg::ST_TOTALBIG)))
        else $error("undefined status code");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
